/* design/tdq_pkg.sv */
`default_nettype none
package tdq_pkg;
   localparam int TIME_W = 63;
   localparam int PER_W  = 40;
   localparam int FID_W  = 16;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_DUP   = 2'd2;
   localparam logic [1:0] ST_NOTFD = 2'd3;
endpackage
`default_nettype wire

/* design/tdq_ram.sv */
`default_nettype none
module tdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* design/timer_deadline_queue.sv */
// Every operation runs one sweep over the timer table through the RAM read
// port, then a finish state prepares the result and an emit state hands it over.
// A tick that expires n timers sweeps n + 1 times.
// One operation at a time; req_stall is high from transfer until the last result
// is loaded into the output register.
// Synchronous reset empties the table (valid bits) and clears the FSM state.
`default_nettype none
module timer_deadline_queue import tdq_pkg::*; #(
   parameter int MAX_TIMERS = 64,
   parameter int ID_BITS    = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_operation,
   input  wire logic [15:0]       req_timer_id,
   input  wire logic [TIME_W-1:0] req_deadline,
   input  wire logic [PER_W-1:0]  req_period,
   input  wire logic [TIME_W-1:0] req_now_time,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [FID_W-1:0]       rsp_fired_id,
   output logic                   rsp_fired,
   output logic [1:0]             rsp_status,
   output logic                   rsp_earliest_changed,
   output logic [TIME_W-1:0]      rsp_next_deadline,
   output logic                   rsp_next_valid,
   output logic                   rsp_last
);
   localparam int AW = $clog2(MAX_TIMERS);
   localparam int CW = $clog2(MAX_TIMERS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0]  dl;
      logic [ID_BITS-1:0] id;
      logic [PER_W-1:0]   per;
   } slot_type;

   logic [1:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [ID_BITS-1:0] tid_ff, tid_in;
   logic [TIME_W-1:0] dl_ff, dl_in, now_ff, now_in;
   logic [PER_W-1:0] per_ff, per_in;
   logic [AW-1:0] addr_ff, addr_in, rd_idx_ff, rd_idx_in;
   logic issue_ff, issue_in, rd_vld_ff, rd_vld_in;
   logic [MAX_TIMERS-1:0] valid_ff, valid_in, taken_ff, taken_in;
   logic [CW-1:0] count_ff, count_in;
   logic min_any_ff, min_any_in;
   logic [TIME_W-1:0] min_dl_ff, min_dl_in;
   logic found_ff, found_in;
   logic [AW-1:0] found_idx_ff, found_idx_in;
   logic free_any_ff, free_any_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic best_any_ff, best_any_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_dl_ff, best_dl_in;
   logic [ID_BITS-1:0] best_id_ff, best_id_in;
   logic [PER_W-1:0] best_per_ff, best_per_in;
   logic prev_any_ff, prev_any_in;
   logic [ID_BITS-1:0] prev_id_ff, prev_id_in;
   logic res_show_ff, res_show_in, res_more_ff, res_more_in;
   logic [FID_W-1:0] res_fid_ff, res_fid_in;
   logic res_fired_ff, res_fired_in, res_ech_ff, res_ech_in;
   logic res_nv_ff, res_nv_in, res_last_ff, res_last_in;
   logic [1:0] res_status_ff, res_status_in;
   logic [TIME_W-1:0] res_next_ff, res_next_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [FID_W-1:0] rsp_fid_ff, rsp_fid_in;
   logic rsp_fired_ff, rsp_fired_in, rsp_ech_ff, rsp_ech_in;
   logic rsp_nv_ff, rsp_nv_in, rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [TIME_W-1:0] rsp_next_ff, rsp_next_in;

   logic wr_en;
   logic [AW-1:0] wr_addr;
   slot_type wr_data, rd_data;
   logic rd_en;
   logic [31:0] id_ext;
   logic [31:0] prev_ext;
   logic [63:0] rearm_sum;
   logic [TIME_W-1:0] rearm_dl;
   logic e_valid, e_taken, start_scan;

   tdq_ram #(.WIDTH($bits(slot_type)), .DEPTH(MAX_TIMERS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign id_ext    = 32'(req_timer_id);
   assign prev_ext  = 32'(prev_id_ff);
   assign rearm_sum = {1'b0, now_ff} + 64'(best_per_ff);
   assign rearm_dl  = rearm_sum[63] ? TIME_MAX : rearm_sum[TIME_W-1:0];
   assign e_valid   = valid_ff[rd_idx_ff];
   assign e_taken   = taken_ff[rd_idx_ff];
   assign rd_en     = (state_ff == S_SCAN) && issue_ff;

   assign req_stall            = reset || (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fired_id         = rsp_fid_ff;
   assign rsp_fired            = rsp_fired_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_earliest_changed = rsp_ech_ff;
   assign rsp_next_deadline    = rsp_next_ff;
   assign rsp_next_valid       = rsp_nv_ff;
   assign rsp_last             = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; tid_in = tid_ff; dl_in = dl_ff; per_in = per_ff; now_in = now_ff;
      addr_in = addr_ff; issue_in = issue_ff;
      rd_vld_in = 1'b0; rd_idx_in = addr_ff;
      valid_in = valid_ff; taken_in = taken_ff; count_in = count_ff;
      min_any_in = min_any_ff; min_dl_in = min_dl_ff;
      found_in = found_ff; found_idx_in = found_idx_ff;
      free_any_in = free_any_ff; free_idx_in = free_idx_ff;
      best_any_in = best_any_ff; best_idx_in = best_idx_ff; best_dl_in = best_dl_ff;
      best_id_in = best_id_ff; best_per_in = best_per_ff;
      prev_any_in = prev_any_ff; prev_id_in = prev_id_ff;
      res_show_in = res_show_ff; res_more_in = res_more_ff; res_fid_in = res_fid_ff;
      res_fired_in = res_fired_ff; res_ech_in = res_ech_ff; res_nv_in = res_nv_ff;
      res_last_in = res_last_ff; res_status_in = res_status_ff; res_next_in = res_next_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_fid_in = rsp_fid_ff; rsp_fired_in = rsp_fired_ff; rsp_ech_in = rsp_ech_ff;
      rsp_nv_in = rsp_nv_ff; rsp_last_in = rsp_last_ff; rsp_status_in = rsp_status_ff;
      rsp_next_in = rsp_next_ff;
      wr_en = 1'b0; wr_addr = best_idx_ff;
      wr_data = '{dl: rearm_dl, id: best_id_ff, per: best_per_ff};
      start_scan = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_operation;
               tid_in = id_ext[ID_BITS-1:0];
               dl_in = req_deadline;
               per_in = req_period;
               now_in = req_now_time;
               taken_in = '0;
               prev_any_in = 1'b0;
               start_scan = 1'b1;
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               rd_vld_in = 1'b1;
               addr_in = addr_ff + AW'(1);
               if (addr_ff == AW'(MAX_TIMERS - 1)) begin
                  issue_in = 1'b0;
               end
            end else if (!rd_vld_ff) begin
               state_in = S_FIN;
            end
            if (rd_vld_ff) begin
               if (e_valid && !((op_ff == OP_CANCEL) && (rd_data.id == tid_ff)) &&
                   (!min_any_ff || rd_data.dl < min_dl_ff)) begin
                  min_any_in = 1'b1;
                  min_dl_in = rd_data.dl;
               end
               if (e_valid && rd_data.id == tid_ff && !found_ff) begin
                  found_in = 1'b1;
                  found_idx_in = rd_idx_ff;
               end
               if (!e_valid && !free_any_ff) begin
                  free_any_in = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (e_valid && !e_taken && rd_data.dl <= now_ff &&
                   (!best_any_ff || rd_data.dl < best_dl_ff ||
                    (rd_data.dl == best_dl_ff && rd_data.id < best_id_ff))) begin
                  best_any_in = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_dl_in = rd_data.dl;
                  best_id_in = rd_data.id;
                  best_per_in = rd_data.per;
               end
            end
         end
         S_FIN: begin
            state_in = S_EMIT;
            res_show_in = 1'b1; res_more_in = 1'b0;
            res_fid_in = '0; res_fired_in = 1'b0; res_ech_in = 1'b0;
            res_status_in = ST_OK; res_last_in = 1'b1;
            res_nv_in = min_any_ff;
            res_next_in = min_any_ff ? min_dl_ff : '0;
            unique case (op_ff)
               OP_ADD: begin
                  if (found_ff) begin
                     res_status_in = ST_DUP;
                  end else if (count_ff == CW'(MAX_TIMERS)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en = 1'b1;
                     wr_addr = free_idx_ff;
                     wr_data = '{dl: dl_ff, id: tid_ff, per: per_ff};
                     valid_in[free_idx_ff] = 1'b1;
                     count_in = count_ff + CW'(1);
                     res_nv_in = 1'b1;
                     if (!min_any_ff || dl_ff < min_dl_ff) begin
                        res_ech_in = 1'b1;
                        res_next_in = dl_ff;
                     end
                  end
               end
               OP_CANCEL: begin
                  if (found_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                     count_in = count_ff - CW'(1);
                  end else begin
                     res_status_in = ST_NOTFD;
                  end
               end
               OP_TICK: begin
                  if (best_any_ff) begin
                     taken_in[best_idx_ff] = 1'b1;
                     if (best_per_ff != '0) begin
                        wr_en = 1'b1;
                     end else begin
                        valid_in[best_idx_ff] = 1'b0;
                        count_in = count_ff - CW'(1);
                     end
                     prev_any_in = 1'b1;
                     prev_id_in = best_id_ff;
                     res_more_in = 1'b1;
                     res_show_in = prev_any_ff;
                     res_fid_in = prev_ext[FID_W-1:0];
                     res_fired_in = 1'b1;
                     res_last_in = 1'b0;
                     res_nv_in = 1'b0;
                     res_next_in = '0;
                  end else if (prev_any_ff) begin
                     res_fid_in = prev_ext[FID_W-1:0];
                     res_fired_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         S_EMIT: begin
            if (!res_show_ff || !rsp_valid_ff) begin
               if (res_show_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_fid_in = res_fid_ff; rsp_fired_in = res_fired_ff;
                  rsp_ech_in = res_ech_ff; rsp_nv_in = res_nv_ff;
                  rsp_last_in = res_last_ff; rsp_status_in = res_status_ff;
                  rsp_next_in = res_next_ff;
               end
               if (res_more_ff) begin
                  start_scan = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (start_scan) begin
         state_in = S_SCAN;
         addr_in = '0; issue_in = 1'b1; rd_vld_in = 1'b0;
         min_any_in = 1'b0; found_in = 1'b0; free_any_in = 1'b0; best_any_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issue_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         valid_ff <= '0;
         taken_ff <= '0;
         count_ff <= '0;
         prev_any_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         rd_vld_ff <= rd_vld_in;
         valid_ff <= valid_in;
         taken_ff <= taken_in;
         count_ff <= count_in;
         prev_any_ff <= prev_any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in; tid_ff <= tid_in; dl_ff <= dl_in; per_ff <= per_in; now_ff <= now_in;
      addr_ff <= addr_in; rd_idx_ff <= rd_idx_in;
      min_any_ff <= min_any_in; min_dl_ff <= min_dl_in;
      found_ff <= found_in; found_idx_ff <= found_idx_in;
      free_any_ff <= free_any_in; free_idx_ff <= free_idx_in;
      best_any_ff <= best_any_in; best_idx_ff <= best_idx_in; best_dl_ff <= best_dl_in;
      best_id_ff <= best_id_in; best_per_ff <= best_per_in;
      prev_id_ff <= prev_id_in;
      res_show_ff <= res_show_in; res_more_ff <= res_more_in; res_fid_ff <= res_fid_in;
      res_fired_ff <= res_fired_in; res_ech_ff <= res_ech_in; res_nv_ff <= res_nv_in;
      res_last_ff <= res_last_in; res_status_ff <= res_status_in; res_next_ff <= res_next_in;
      rsp_fid_ff <= rsp_fid_in; rsp_fired_ff <= rsp_fired_in; rsp_ech_ff <= rsp_ech_in;
      rsp_nv_ff <= rsp_nv_in; rsp_last_ff <= rsp_last_in; rsp_status_ff <= rsp_status_in;
      rsp_next_ff <= rsp_next_in;
   end
endmodule
`default_nettype wire

/* design/tdq_checker.sv */
`default_nettype none
module tdq_checker import tdq_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [FID_W-1:0]  rsp_fired_id,
   input wire logic              rsp_fired,
   input wire logic [1:0]        rsp_status,
   input wire logic              rsp_earliest_changed,
   input wire logic [TIME_W-1:0] rsp_next_deadline,
   input wire logic              rsp_next_valid,
   input wire logic              rsp_last
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fired_id) && $stable(rsp_last))
      else $error("stalled result changed");

   a_nofire_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_last)
      else $error("non-fire result not last");

   a_mid_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_fired && !rsp_next_valid && rsp_next_deadline == '0)
      else $error("mid-tick result carries next deadline");

   a_ech: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_earliest_changed |-> rsp_status == ST_OK && rsp_next_valid && !rsp_fired)
      else $error("earliest_changed on a failed add");
endmodule

bind timer_deadline_queue tdq_checker u_tdq_checker (.*);
`default_nettype wire
